>>> hdl/tsm_pkg.sv
// Shared types, codes and defaults for the topic subscription matcher
`default_nettype none
package tsm_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int MAX_LEN_DEF = 64;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REM = 2'd1;
  localparam logic [1:0] OP_PUB = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_PUBLISH  = 3'd5;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef struct packed {
    logic [1:0] op;
    logic       ovf;
    logic       dollar;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_EQ_RD, S_EQ_CK, S_DECIDE, S_W_TOP, S_W_EV, S_W_END,
    S_W_PL, S_W_PLEV, S_HIT, S_CP_RD, S_CP_WR, S_FIN
  } state_t;

endpackage
`default_nettype wire

>>> hdl/tsm_front.sv
// Front end: stages string bytes and issues one command per final byte
`default_nettype none
module tsm_front #(
  parameter int MAX_LEN = tsm_pkg::MAX_LEN_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [1:0]                        op,
  input  wire [7:0]                        char_byte,
  input  wire                              last_char,
  output logic                             push,
  output tsm_pkg::cmd_t                    push_cmd,
  output logic [$clog2(MAX_LEN+1)-1:0]     push_cnt,
  input  wire                              done,
  input  wire [$clog2(MAX_LEN)-1:0]        raddr,
  output logic [7:0]                       rdata
);
  import tsm_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  logic [7:0]    smem [MAX_LEN];
  logic [LW-1:0] cnt;
  logic          ovf;
  logic          dollar;
  logic          held;
  logic          take;
  logic          room;

  assign in_ready = !held;
  assign take     = in_valid && in_ready && (op != OP_NOP);
  assign room     = cnt < LW'(MAX_LEN);
  assign push     = take && last_char;

  always_comb begin
    push_cmd.op     = op;
    push_cmd.ovf    = ovf || !room;
    push_cmd.dollar = (cnt == '0) ? (char_byte == CH_DOLLAR) : dollar;
    push_cnt        = room ? cnt + LW'(1) : cnt;
  end

  always_ff @(posedge clk) begin
    if (take && room) begin
      smem[cnt[AW-1:0]] <= char_byte;
    end
    rdata <= smem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      ovf    <= 1'b0;
      held   <= 1'b0;
      dollar <= 1'b0;
    end else begin
      if (push) begin
        cnt  <= '0;
        ovf  <= 1'b0;
        held <= 1'b1;
      end else if (take) begin
        if (room) begin
          cnt <= cnt + LW'(1);
        end else begin
          ovf <= 1'b1;
        end
        if (cnt == '0) begin
          dollar <= (char_byte == CH_DOLLAR);
        end
      end
      if (done) begin
        held <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/tsm_queue.sv
// Two-entry command queue between front and back
`default_nettype none
module tsm_queue #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  wire [W-1:0]  wdata,
  input  wire          pop,
  output logic         valid,
  output logic [W-1:0] rdata
);
  import tsm_pkg::*;

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;
  logic         do_push;
  logic         do_pop;

  assign valid   = fill != 2'd0;
  assign rdata   = mem[rp];
  assign do_push = push && (fill != 2'd2);
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

>>> hdl/tsm_back.sv
// Back end: slot scan, compare and wildcard walk, table update, result register
`default_nettype none
module tsm_back #(
  parameter int SLOTS   = tsm_pkg::SLOTS_DEF,
  parameter int MAX_LEN = tsm_pkg::MAX_LEN_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           q_valid,
  input  tsm_pkg::cmd_t                 q_cmd,
  input  wire [$clog2(MAX_LEN+1)-1:0]   q_cnt,
  output logic                          q_pop,
  output logic [$clog2(MAX_LEN)-1:0]    s_raddr,
  input  wire [7:0]                     srd,
  output logic                          done,
  input  wire                           out_ready,
  output logic                          out_valid,
  output logic [2:0]                    status,
  output logic                          hit,
  output logic [2:0]                    slot_index,
  output logic                          too_long,
  output logic                          last_result
);
  import tsm_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FA = (SLOTS * MAX_LEN > 1) ? $clog2(SLOTS * MAX_LEN) : 1;
  localparam int E  = LW + 2;

  function automatic logic [2:0] sl3(input logic [SW-1:0] x);
    logic [SW+2:0] w;
    w = {3'b000, x};
    return w[2:0];
  endfunction

  logic [7:0]    fmem [SLOTS*MAX_LEN];
  logic [7:0]    frd;
  logic [LW-1:0] flen [SLOTS];

  state_t        state;
  state_t        state_next;
  logic [1:0]    op;
  logic          dollar;
  logic [LW-1:0] nl;
  logic [CW-1:0] s;
  logic [LW-1:0] ni;
  logic [LW-1:0] fi;
  logic          eqr;
  logic          dup;
  logic          pend;
  logic [SW-1:0] pend_s;
  logic          want_hash;
  logic [2:0]    fin_status;
  logic          fin_hit;
  logic [SW-1:0] fin_slot;
  logic          fin_tl;

  logic [SW-1:0] s_idx;
  logic [LW-1:0] cur_len;
  logic          at_end;
  logic          occ;
  logic          wt_go;
  logic          near3;
  logic          near2;
  logic          byte_eq;
  logic          last_i;
  logic          out_free;
  logic          out_load;
  logic [FA-1:0] base;
  logic [LW:0]   foff;
  logic [FA-1:0] faddr;
  logic [FA-1:0] fwaddr;
  logic          fwe;

  assign s_idx    = s[SW-1:0];
  assign at_end   = s == CW'(SLOTS);
  assign cur_len  = flen[s_idx];
  assign occ      = cur_len != '0;
  assign wt_go    = (ni < nl) && (fi < cur_len);
  assign near3    = (E'(ni) + E'(1) == E'(nl)) && (E'(fi) + E'(3) == E'(cur_len));
  assign near2    = (E'(ni) + E'(1) == E'(nl)) && (E'(fi) + E'(2) == E'(cur_len));
  assign byte_eq  = srd == frd;
  assign last_i   = E'(ni) + E'(1) == E'(nl);
  assign out_free = !out_valid || out_ready;
  assign base     = FA'(FA'(s_idx) * FA'(MAX_LEN));
  assign s_raddr  = ni[AW-1:0];
  assign q_pop    = (state == S_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = q_cmd.ovf ? S_FIN : S_SLOT;
        end
      end
      S_SLOT: begin
        if (at_end) begin
          state_next = S_FIN;
        end else if (!occ) begin
          if (op == OP_ADD) begin
            state_next = dup ? S_FIN : S_CP_RD;
          end
        end else if (cur_len == nl) begin
          state_next = S_EQ_RD;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_EQ_RD: state_next = S_EQ_CK;
      S_EQ_CK: begin
        if (!byte_eq || last_i) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_EQ_RD;
        end
      end
      S_DECIDE: begin
        if (op == OP_ADD) begin
          state_next = S_SLOT;
        end else if (op == OP_REM) begin
          state_next = eqr ? S_FIN : S_SLOT;
        end else if (eqr) begin
          state_next = S_HIT;
        end else begin
          state_next = dollar ? S_SLOT : S_W_TOP;
        end
      end
      S_W_TOP: begin
        if (wt_go) begin
          state_next = S_W_EV;
        end else if ((ni == nl) && (fi == cur_len)) begin
          state_next = S_HIT;
        end else begin
          state_next = S_SLOT;
        end
      end
      S_W_EV: begin
        if (byte_eq) begin
          state_next = (near3 || near2) ? S_W_END : S_W_TOP;
        end else if (frd == CH_PLUS) begin
          state_next = S_W_PL;
        end else if (frd == CH_HASH) begin
          state_next = S_HIT;
        end else begin
          state_next = S_SLOT;
        end
      end
      S_W_END: begin
        if (frd == (want_hash ? CH_HASH : CH_PLUS)) begin
          state_next = S_HIT;
        end else begin
          state_next = S_W_TOP;
        end
      end
      S_W_PL:   state_next = (ni < nl) ? S_W_PLEV : S_W_TOP;
      S_W_PLEV: state_next = (srd != CH_SLASH) ? S_W_PL : S_W_TOP;
      S_HIT: begin
        if (!pend || out_free) begin
          state_next = S_SLOT;
        end
      end
      S_CP_RD: state_next = S_CP_WR;
      S_CP_WR: state_next = last_i ? S_FIN : S_CP_RD;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    foff     = {1'b0, fi};
    fwe      = 1'b0;
    out_load = 1'b0;
    done     = 1'b0;
    unique case (state)
      S_EQ_RD: foff = {1'b0, ni};
      S_W_EV:  foff = {1'b0, fi} + (near3 ? (LW+1)'(2) : (LW+1)'(1));
      S_CP_WR: fwe = 1'b1;
      S_HIT:   out_load = pend && out_free;
      S_FIN: begin
        out_load = out_free;
        done     = out_free;
      end
      default: foff = {1'b0, fi};
    endcase
    faddr  = base + FA'(foff);
    fwaddr = base + FA'(ni);
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      fmem[fwaddr] <= srd;
    end
    frd <= fmem[faddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        flen[k] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            pend <= 1'b0;
          end
        end
        S_DECIDE: begin
          if ((op == OP_REM) && eqr) begin
            flen[s_idx] <= '0;
          end
        end
        S_HIT: begin
          if (!pend) begin
            pend <= 1'b1;
          end
        end
        S_CP_WR: begin
          if (last_i) begin
            flen[s_idx] <= nl;
          end
        end
        default: pend <= pend;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op       <= q_cmd.op;
        dollar   <= q_cmd.dollar;
        nl       <= q_cnt;
        s        <= '0;
        dup      <= 1'b0;
        fin_hit  <= 1'b0;
        fin_slot <= '0;
        fin_tl   <= 1'b1;
        case (q_cmd.op)
          OP_ADD:  fin_status <= ST_FULL;
          OP_REM:  fin_status <= ST_NOTFOUND;
          default: fin_status <= ST_PUBLISH;
        endcase
      end
      S_SLOT: begin
        ni     <= '0;
        fin_tl <= 1'b0;
        if (at_end) begin
          fin_hit  <= 1'b0;
          fin_slot <= '0;
          if (op == OP_ADD) begin
            fin_status <= dup ? ST_DUP : ST_FULL;
          end else if (op == OP_REM) begin
            fin_status <= ST_NOTFOUND;
          end else begin
            fin_status <= ST_PUBLISH;
            fin_hit    <= pend;
            fin_slot   <= pend ? pend_s : '0;
          end
        end else if (!occ) begin
          if (op == OP_ADD) begin
            fin_status <= ST_DUP;
            fin_hit    <= 1'b0;
            fin_slot   <= '0;
          end else begin
            s <= s + CW'(1);
          end
        end else if (cur_len != nl) begin
          eqr <= 1'b0;
        end
      end
      S_EQ_CK: begin
        if (!byte_eq) begin
          eqr <= 1'b0;
        end else if (last_i) begin
          eqr <= 1'b1;
        end else begin
          ni <= ni + LW'(1);
        end
      end
      S_DECIDE: begin
        ni <= '0;
        fi <= '0;
        if (op == OP_ADD) begin
          dup <= dup || eqr;
          s   <= s + CW'(1);
        end else if (op == OP_REM) begin
          if (eqr) begin
            fin_status <= ST_REMOVED;
            fin_hit    <= 1'b0;
            fin_slot   <= s_idx;
          end else begin
            s <= s + CW'(1);
          end
        end else if (!eqr && dollar) begin
          s <= s + CW'(1);
        end
      end
      S_W_TOP: begin
        if (!wt_go && !((ni == nl) && (fi == cur_len))) begin
          s <= s + CW'(1);
        end
      end
      S_W_EV: begin
        if (byte_eq) begin
          want_hash <= near3;
          if (!near3 && !near2) begin
            ni <= ni + LW'(1);
            fi <= fi + LW'(1);
          end
        end else if (frd == CH_PLUS) begin
          fi <= fi + LW'(1);
        end else if (frd != CH_HASH) begin
          s <= s + CW'(1);
        end
      end
      S_W_END: begin
        if (frd != (want_hash ? CH_HASH : CH_PLUS)) begin
          ni <= ni + LW'(1);
          fi <= fi + LW'(1);
        end
      end
      S_W_PLEV: begin
        if (srd != CH_SLASH) begin
          ni <= ni + LW'(1);
        end
      end
      S_HIT: begin
        if (!pend || out_free) begin
          pend_s <= s_idx;
          s      <= s + CW'(1);
        end
      end
      S_CP_WR: begin
        if (last_i) begin
          fin_status <= ST_ADDED;
          fin_hit    <= 1'b0;
          fin_slot   <= s_idx;
        end else begin
          ni <= ni + LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_FIN) begin
        status      <= fin_status;
        hit         <= fin_hit;
        slot_index  <= sl3(fin_slot);
        too_long    <= fin_tl;
        last_result <= 1'b1;
      end else begin
        status      <= ST_PUBLISH;
        hit         <= 1'b1;
        slot_index  <= sl3(pend_s);
        too_long    <= 1'b0;
        last_result <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/topic_subscription_matcher_core.sv
// Top level of the topic subscription matcher
//
//   channel | direction | handshake           | payload
//   in      | in        | in_valid / in_ready | op, char_byte, last_char
//   out     | out       | out_valid/out_ready | status, hit, slot_index, too_long, last_result
//
// Non-final bytes are taken one per cycle into the staging buffer while intake is open.
// A final byte blocks intake until its last result is registered; the back end
// scans slots in order over a single filter-store read port, and add copies the
// string into a free slot byte by byte.
// Synchronous reset clears slot lengths, staging and control; stores need no clear.
// A stalled output holds the back end; intake resumes while the final item waits.
`default_nettype none
module topic_subscription_matcher_core #(
  parameter int SLOTS   = tsm_pkg::SLOTS_DEF,
  parameter int MAX_LEN = tsm_pkg::MAX_LEN_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  op,
  input  wire [7:0]  char_byte,
  input  wire        last_char,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [2:0] status,
  output logic       hit,
  output logic [2:0] slot_index,
  output logic       too_long,
  output logic       last_result
);
  import tsm_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int QW = $bits(cmd_t) + LW;

  logic          push;
  cmd_t          push_cmd;
  logic [LW-1:0] push_cnt;
  logic          done;
  logic [AW-1:0] s_raddr;
  logic [7:0]    srd;
  logic          q_valid;
  logic [QW-1:0] q_data;
  logic          q_pop;
  cmd_t          q_cmd;
  logic [LW-1:0] q_cnt;

  assign q_cmd = q_data[QW-1:LW];
  assign q_cnt = q_data[LW-1:0];

  tsm_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .char_byte(char_byte), .last_char(last_char),
    .push(push), .push_cmd(push_cmd), .push_cnt(push_cnt),
    .done(done), .raddr(s_raddr), .rdata(srd)
  );

  tsm_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .wdata({push_cmd, push_cnt}),
    .pop(q_pop), .valid(q_valid), .rdata(q_data)
  );

  tsm_back #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_cnt(q_cnt), .q_pop(q_pop),
    .s_raddr(s_raddr), .srd(srd), .done(done),
    .out_ready(out_ready), .out_valid(out_valid),
    .status(status), .hit(hit), .slot_index(slot_index),
    .too_long(too_long), .last_result(last_result)
  );

endmodule
`default_nettype wire

>>> hdl/tsm_checker.sv
// Port-level checks for the topic subscription matcher
`default_nettype none
module tsm_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_ready,
  input wire [1:0] op,
  input wire [7:0] char_byte,
  input wire       last_char,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] status,
  input wire       hit,
  input wire [2:0] slot_index,
  input wire       too_long,
  input wire       last_result
);
  import tsm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_intake_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_char && (op != OP_NOP) |=> !in_ready)
    else $error("intake open after final byte");

  a_hit_pub: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> (status == ST_PUBLISH) && !too_long)
    else $error("hit on non-publish item");

  a_long_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> last_result && !hit && (slot_index == 3'd0))
    else $error("overlong item not single");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_PUBLISH) |-> last_result)
    else $error("add or remove gave several items");

endmodule

bind topic_subscription_matcher_core tsm_checker u_tsm_checker (.*);
`default_nettype wire
